FILE: rtl/kefuf_pkg.sv
// shared types and constants for the kruskal edge filter
// field widths, saturation limits and the sequencer state encoding
// no dependencies
package kefuf_pkg;

    localparam int NODE_W      = 10;
    localparam int WEIGHT_W    = 32;
    localparam int COST_W      = 48;
    localparam int COUNT_W     = 10;
    localparam int RANK_W      = 4;
    // wide enough to hold any node count of the parameter range
    localparam int WIDE_NODE_W = 17;

    // stream payload widths, padded to whole bytes
    localparam int S_DATA_W    = 56;
    localparam int M_DATA_W    = 64;

    localparam logic [COST_W-1:0]  COST_MAX  = {COST_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [RANK_W-1:0]  RANK_MAX  = {RANK_W{1'b1}};

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_FCHK  = 7'b0000100,
        S_CCHK  = 7'b0001000,
        S_RKA   = 7'b0010000,
        S_RKB   = 7'b0100000,
        S_DONE  = 7'b1000000
    } kefuf_state_t;

endpackage

FILE: rtl/kruskal_edge_filter_union_find.sv
// kruskal edge filter: disjoint-set forest with path compression and union by rank
// depends on kefuf_pkg and kefuf_ram (parent and rank memories)
//
//  channel  | dir | tdata fields (lsb first)                              | beat
//  ---------+-----+-------------------------------------------------------+------------------
//  s_axis   | in  | node_a[9:0] node_b[19:10] edge_weight[51:20] pad      | one edge
//  m_axis   | out | accepted[0] joins_source[1] total_cost[49:2]          | one result
//           |     | accepted_count[59:50] pad                             |
//
// each taken edge walks node_a and then node_b to its root through the single read port
//   of the parent memory; a walk of nonzero length is followed by a compression pass
//   that points each node of the walk at the root
// an edge whose ends already share a root skips the rank states S_RKA and S_RKB
// self loops and out-of-range endpoints go from S_IDLE straight to S_DONE
// after reset a clearing pass over all NODE_COUNT addresses initializes both memories;
//   s_tready stays low until it ends
// the result sits in an output register; the next edge is taken while it waits,
//   and the sequencer only stalls at its final step if the old result is still held
module kruskal_edge_filter_union_find #(
    parameter int NODE_COUNT  = 1024,
    parameter int WEIGHT_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // node_a[9:0], node_b[19:10], edge_weight[51:20], zero pad [55:52]
    input  logic [kefuf_pkg::S_DATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // accepted[0], joins_source[1], total_cost[49:2], accepted_count[59:50], pad
    output logic [kefuf_pkg::M_DATA_W-1:0] m_tdata
);
    import kefuf_pkg::*;

    localparam int ADDR_W = $clog2(NODE_COUNT);
    localparam logic [ADDR_W-1:0]      CLR_LAST   = ADDR_W'(NODE_COUNT - 1);
    localparam logic [WIDE_NODE_W-1:0] NODE_LIMIT = WIDE_NODE_W'(NODE_COUNT);
    // only the low WEIGHT_BITS bits of the weight count
    localparam logic [WEIGHT_W-1:0]    W_MASK     = (WEIGHT_BITS >= WEIGHT_W) ?
        {WEIGHT_W{1'b1}} : WEIGHT_W'((64'd1 << WEIGHT_BITS) - 64'd1);

    // sequencer and datapath registers
    kefuf_state_t        state_reg, state_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [NODE_W-1:0]   a_reg, a_next;
    logic [NODE_W-1:0]   b_reg, b_next;
    logic [WEIGHT_W-1:0] w_reg, w_next;
    logic                side_reg, side_next;     // 0: resolving node_a, 1: node_b
    logic [ADDR_W-1:0]   cur_reg, cur_next;       // node being walked
    logic [ADDR_W-1:0]   start_reg, start_next;   // start of the current walk
    logic [ADDR_W-1:0]   root_reg, root_next;
    logic [ADDR_W-1:0]   ra_reg, ra_next;
    logic [ADDR_W-1:0]   rb_reg, rb_next;
    logic [RANK_W-1:0]   rka_reg, rka_next;
    logic                took_reg, took_next;
    logic [COST_W-1:0]   cost_reg, cost_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;

    // output register
    logic                m_valid_reg, m_valid_next;
    logic                m_acc_reg, m_acc_next;
    logic                m_src_reg, m_src_next;
    logic [COST_W-1:0]   m_cost_reg, m_cost_next;
    logic [COUNT_W-1:0]  m_cnt_reg, m_cnt_next;

    // memory ports
    logic                p_we;
    logic [ADDR_W-1:0]   p_waddr, p_wdata, p_raddr, p_rdata;
    logic                r_we;
    logic [ADDR_W-1:0]   r_waddr, r_raddr;
    logic [RANK_W-1:0]   r_wdata, r_rdata;

    // input field view
    logic [NODE_W-1:0]      in_a, in_b;
    logic [WEIGHT_W-1:0]    in_w;
    logic [WIDE_NODE_W-1:0] in_a_wide, in_b_wide, b_wide;
    logic [ADDR_W-1:0]      in_a_addr, b_addr;
    logic                   in_ok;

    // find completion
    logic                   find_done;
    logic [ADDR_W-1:0]      found_root;
    logic [COST_W:0]        cost_sum;

    assign in_a      = s_tdata[NODE_W-1:0];
    assign in_b      = s_tdata[2*NODE_W-1:NODE_W];
    assign in_w      = s_tdata[2*NODE_W+WEIGHT_W-1:2*NODE_W];
    assign in_a_wide = {{(WIDE_NODE_W-NODE_W){1'b0}}, in_a};
    assign in_b_wide = {{(WIDE_NODE_W-NODE_W){1'b0}}, in_b};
    assign b_wide    = {{(WIDE_NODE_W-NODE_W){1'b0}}, b_reg};
    assign in_a_addr = in_a_wide[ADDR_W-1:0];
    assign b_addr    = b_wide[ADDR_W-1:0];
    // out-of-range endpoints and self loops never change the forest
    assign in_ok     = (in_a_wide < NODE_LIMIT) && (in_b_wide < NODE_LIMIT) && (in_a != in_b);

    assign cost_sum  = {1'b0, cost_reg} + {{(COST_W-WEIGHT_W+1){1'b0}}, w_reg};

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(M_DATA_W-2-COST_W-COUNT_W){1'b0}},
                        m_cnt_reg, m_cost_reg, m_src_reg, m_acc_reg};

    kefuf_ram #(.DATA_W(ADDR_W), .DEPTH(NODE_COUNT)) u_parent_ram (
        .clk   (aclk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    kefuf_ram #(.DATA_W(RANK_W), .DEPTH(NODE_COUNT)) u_rank_ram (
        .clk   (aclk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        w_next       = w_reg;
        side_next    = side_reg;
        cur_next     = cur_reg;
        start_next   = start_reg;
        root_next    = root_reg;
        ra_next      = ra_reg;
        rb_next      = rb_reg;
        rka_next     = rka_reg;
        took_next    = took_reg;
        cost_next    = cost_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_acc_next   = m_acc_reg;
        m_src_next   = m_src_reg;
        m_cost_next  = m_cost_reg;
        m_cnt_next   = m_cnt_reg;

        p_we       = 1'b0;
        p_waddr    = cur_reg;
        p_wdata    = root_reg;
        p_raddr    = cur_reg;
        r_we       = 1'b0;
        r_waddr    = ra_reg;
        r_wdata    = '0;
        r_raddr    = ra_reg;
        find_done  = 1'b0;
        found_root = root_reg;

        unique case (state_reg)
            S_CLEAR: begin
                // every node its own root at rank zero
                p_we     = 1'b1;
                p_waddr  = clr_reg;
                p_wdata  = clr_reg;
                r_we     = 1'b1;
                r_waddr  = clr_reg;
                r_wdata  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    a_next = in_a;
                    b_next = in_b;
                    w_next = in_w & W_MASK;
                    if (in_ok) begin
                        side_next  = 1'b0;
                        cur_next   = in_a_addr;
                        start_next = in_a_addr;
                        p_raddr    = in_a_addr;
                        state_next = S_FCHK;
                    end else begin
                        took_next  = 1'b0;
                        state_next = S_DONE;
                    end
                end
            end
            S_FCHK: begin
                // p_rdata is the parent of cur
                if (p_rdata == cur_reg) begin
                    root_next = cur_reg;
                    if (start_reg == cur_reg) begin
                        find_done  = 1'b1;
                        found_root = cur_reg;
                    end else begin
                        // second pass: point every node of the walk at the root
                        cur_next   = start_reg;
                        p_raddr    = start_reg;
                        state_next = S_CCHK;
                    end
                end else begin
                    cur_next = p_rdata;
                    p_raddr  = p_rdata;
                end
            end
            S_CCHK: begin
                p_we    = 1'b1;
                p_waddr = cur_reg;
                p_wdata = root_reg;
                if (p_rdata == root_reg) begin
                    find_done  = 1'b1;
                    found_root = root_reg;
                end else begin
                    cur_next = p_rdata;
                    p_raddr  = p_rdata;
                end
            end
            S_RKA: begin
                rka_next   = r_rdata;
                r_raddr    = rb_reg;
                state_next = S_RKB;
            end
            S_RKB: begin
                // r_rdata is the rank of rb
                p_we = 1'b1;
                if (rka_reg > r_rdata) begin
                    p_waddr = rb_reg;
                    p_wdata = ra_reg;
                end else begin
                    p_waddr = ra_reg;
                    p_wdata = rb_reg;
                    if ((rka_reg == r_rdata) && (r_rdata != RANK_MAX)) begin
                        r_we    = 1'b1;
                        r_waddr = rb_reg;
                        r_wdata = r_rdata + 1'b1;
                    end
                end
                cost_next  = cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];
                cnt_next   = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
                took_next  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_acc_next   = took_reg;
                    m_src_next   = took_reg && (a_reg == '0);
                    m_cost_next  = cost_reg;
                    m_cnt_next   = cnt_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (find_done) begin
            if (!side_reg) begin
                ra_next    = found_root;
                side_next  = 1'b1;
                cur_next   = b_addr;
                start_next = b_addr;
                p_raddr    = b_addr;
                state_next = S_FCHK;
            end else if (found_root == ra_reg) begin
                // both ends already in one set
                took_next  = 1'b0;
                state_next = S_DONE;
            end else begin
                rb_next    = found_root;
                r_raddr    = ra_reg;
                state_next = S_RKA;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            cost_reg    <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            cost_reg    <= cost_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        w_reg      <= w_next;
        side_reg   <= side_next;
        cur_reg    <= cur_next;
        start_reg  <= start_next;
        root_reg   <= root_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        rka_reg    <= rka_next;
        took_reg   <= took_next;
        m_acc_reg  <= m_acc_next;
        m_src_reg  <= m_src_next;
        m_cost_reg <= m_cost_next;
        m_cnt_reg  <= m_cnt_next;
    end

endmodule

FILE: rtl/kefuf_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// read returns the old contents on a same-address write
// no dependencies
module kefuf_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/kefuf_checker.sv
// port-level checker for the kruskal edge filter and its bind statement
// depends on kefuf_pkg; watches the stream ports of the top level only
module kefuf_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [kefuf_pkg::M_DATA_W-1:0] m_tdata
);
    import kefuf_pkg::*;

    logic               m_beat;
    logic               acc, src;
    logic [COST_W-1:0]  cost;
    logic [COUNT_W-1:0] cnt;
    logic [COST_W-1:0]  prev_cost_reg;
    logic [COUNT_W-1:0] prev_cnt_reg;
    logic [COUNT_W-1:0] cnt_step;
    logic               s_beat;

    assign m_beat   = m_tvalid && m_tready;
    assign s_beat   = s_tvalid && s_tready;
    assign acc      = m_tdata[0];
    assign src      = m_tdata[1];
    assign cost     = m_tdata[COST_W+1:2];
    assign cnt      = m_tdata[COST_W+COUNT_W+1:COST_W+2];
    assign cnt_step = (prev_cnt_reg == COUNT_MAX) ? prev_cnt_reg : prev_cnt_reg + 1'b1;

    // totals of the last delivered result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_cost_reg <= '0;
            prev_cnt_reg  <= '0;
        end else if (m_beat) begin
            prev_cost_reg <= cost;
            prev_cnt_reg  <= cnt;
        end
    end

    // a source flag only on a taken edge
    a_src_needs_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && src |-> acc)
        else $error("joins_source without accepted");

    // a taken edge bumps the count by one, saturating, and the cost never falls
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_beat && acc |-> (cnt == cnt_step) && (cost >= prev_cost_reg))
        else $error("accepted_count did not step or total_cost decreased");

    // a rejected edge leaves both totals alone
    a_reject_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_beat && !acc |-> (cnt == prev_cnt_reg) && (cost == prev_cost_reg))
        else $error("totals changed on a rejected edge");

    // one edge at a time: the input closes right after a beat
    a_in_one_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat |=> !s_tready)
        else $error("input stayed ready after an edge beat");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

endmodule

bind kruskal_edge_filter_union_find kefuf_checker u_kefuf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
